/* hdl/motor_command_frame_parser_defines.svh */
// Assertion macros for the motor command frame parser checker.
// Needs nothing else; include it by its bare file name.
`ifndef MOTOR_COMMAND_FRAME_PARSER_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, muted while reset is asserted.
`define MCFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mcfp same-cycle check failed");

// Next-cycle implication, muted while reset is asserted.
`define MCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mcfp next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define MCFP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mcfp reset check failed");

`endif

/* hdl/mcfp_pkg.sv */
// Shared types, character codes and helper functions of the motor command frame parser.
// Depends on nothing; every other file but the defines header imports it.
package mcfp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SPEED_W  = 8;
    localparam int unsigned ANGLE_W  = 6;
    localparam int unsigned BODY_LEN = 7;
    localparam int unsigned POS_W    = 3;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BODY_LEN);

    localparam logic [BYTE_W-1:0] CH_TERM_UC = 8'h45; // 'E'
    localparam logic [BYTE_W-1:0] CH_TERM_LC = 8'h65; // 'e'
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30; // '0'
    localparam logic [BYTE_W-1:0] CH_ONE     = 8'h31; // '1'
    localparam logic [BYTE_W-1:0] CH_FOUR    = 8'h34; // '4'
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39; // '9'
    localparam logic [BYTE_W-1:0] CH_FWD_LC  = 8'h66; // 'f'
    localparam logic [BYTE_W-1:0] CH_FWD_UC  = 8'h46; // 'F'
    localparam logic [BYTE_W-1:0] CH_BWD_LC  = 8'h62; // 'b'
    localparam logic [BYTE_W-1:0] CH_BWD_UC  = 8'h42; // 'B'
    localparam logic [BYTE_W-1:0] CH_LEFT_LC = 8'h6C; // 'l'
    localparam logic [BYTE_W-1:0] CH_LEFT_UC = 8'h4C; // 'L'
    localparam logic [BYTE_W-1:0] CH_RGHT_LC = 8'h72; // 'r'
    localparam logic [BYTE_W-1:0] CH_RGHT_UC = 8'h52; // 'R'

    localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd199;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 6'd49;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_percent;
        logic               go_backward;
        logic [ANGLE_W-1:0] angle_value;
        logic               turn_left;
    } t_cmd;

    function automatic logic is_term(input logic [BYTE_W-1:0] c);
        return (c == CH_TERM_UC) || (c == CH_TERM_LC);
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c,
                                      input logic [BYTE_W-1:0] top);
        return (c >= CH_ZERO) && (c <= top);
    endfunction

    // Digit value; only meaningful once the character passed is_digit.
    function automatic logic [3:0] digit_val(input logic [BYTE_W-1:0] c);
        return c[3:0];
    endfunction

endpackage

/* hdl/mcfp_if.sv */
// Valid/ready channels of the motor command frame parser: received bytes and decoded commands.
// Depends on mcfp_pkg.
interface mcfp_byte_if;
    import mcfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mcfp_cmd_if;
    import mcfp_pkg::*;

    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] speed_percent;
    logic               go_backward;
    logic [ANGLE_W-1:0] angle_value;
    logic               turn_left;

    modport source (output valid, output speed_percent, output go_backward,
                    output angle_value, output turn_left, input ready);
    modport sink   (input valid, input speed_percent, input go_backward,
                    input angle_value, input turn_left, output ready);
endinterface

/* hdl/mcfp_in_stage.sv */
// Input register of the motor command frame parser: holds one received byte.
// Depends on mcfp_pkg and mcfp_byte_if.
module mcfp_in_stage (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    mcfp_byte_if.sink                 i_rx,
    input  logic                      i_advance,
    output logic                      o_valid,
    output logic [mcfp_pkg::BYTE_W-1:0] o_byte
);
    import mcfp_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              w_take;

    // Accept when empty or when the held byte moves on this cycle.
    assign i_rx.ready = !r_valid || i_advance;
    assign w_take     = i_rx.valid && i_rx.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

/* hdl/mcfp_frame_core.sv */
// Frame assembly and decode: character position, held characters, checks and digit arithmetic.
// Depends on mcfp_pkg.
module mcfp_frame_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic [mcfp_pkg::BYTE_W-1:0] i_byte,
    output logic                        o_res_valid,
    output mcfp_pkg::t_cmd              o_res
);
    import mcfp_pkg::*;

    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [BYTE_W-1:0] r_held [BODY_LEN];
    logic              w_term;
    logic              w_store;
    logic              w_body_ok;

    assign w_term  = is_term(i_byte);
    assign w_store = i_advance && !w_term && (r_pos != POS_LAST);

    // Restart at slot 0 on any terminator or on a stray byte in the last slot.
    always_comb begin
        n_pos = r_pos;
        if (i_advance) begin
            if (w_term || (r_pos == POS_LAST)) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_held[r_pos] <= i_byte;
        end
    end

    assign w_body_ok = ((r_held[0] == CH_ZERO) || (r_held[0] == CH_ONE))
                    && is_digit(r_held[1], CH_NINE)
                    && is_digit(r_held[2], CH_NINE)
                    && ((r_held[3] == CH_FWD_LC) || (r_held[3] == CH_FWD_UC)
                     || (r_held[3] == CH_BWD_LC) || (r_held[3] == CH_BWD_UC))
                    && is_digit(r_held[4], CH_FOUR)
                    && is_digit(r_held[5], CH_NINE)
                    && ((r_held[6] == CH_LEFT_LC) || (r_held[6] == CH_LEFT_UC)
                     || (r_held[6] == CH_RGHT_LC) || (r_held[6] == CH_RGHT_UC));

    assign o_res_valid = i_advance && w_term && (r_pos == POS_LAST) && w_body_ok;

    always_comb begin
        o_res.speed_percent = (SPEED_W'(digit_val(r_held[0])) * SPEED_W'(100))
                            + (SPEED_W'(digit_val(r_held[1])) * SPEED_W'(10))
                            + SPEED_W'(digit_val(r_held[2]));
        o_res.go_backward   = (r_held[3] == CH_BWD_LC) || (r_held[3] == CH_BWD_UC);
        o_res.angle_value   = (ANGLE_W'(digit_val(r_held[4])) * ANGLE_W'(10))
                            + ANGLE_W'(digit_val(r_held[5]));
        o_res.turn_left     = (r_held[6] == CH_LEFT_LC) || (r_held[6] == CH_LEFT_UC);
    end
endmodule

/* hdl/mcfp_out_stage.sv */
// Result register of the motor command frame parser: holds one decoded command until taken.
// Depends on mcfp_pkg and mcfp_cmd_if.
module mcfp_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_advance,
    input  logic           i_res_valid,
    input  mcfp_pkg::t_cmd i_res,
    output logic           o_free,
    mcfp_cmd_if.source     o_cmd
);
    import mcfp_pkg::*;

    logic r_valid;
    logic n_valid;
    t_cmd r_res;

    assign o_free = !r_valid || o_cmd.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_advance) begin
            n_valid = i_res_valid;
        end else if (o_cmd.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_cmd.valid         = r_valid;
    assign o_cmd.speed_percent = r_res.speed_percent;
    assign o_cmd.go_backward   = r_res.go_backward;
    assign o_cmd.angle_value   = r_res.angle_value;
    assign o_cmd.turn_left     = r_res.turn_left;
endmodule

/* hdl/motor_command_frame_parser.sv */
// A terminator's command is decoded combinationally and held in the result register.
// Throughput: one byte per cycle, set by the input register and the result register in line;
// a command held by a stalled sink holds the next byte in the input register.
// A byte that completes no frame takes its cycle in the core and yields no request.
// Reset (i_rst_n low, synchronous) empties both registers and restarts framing at slot 0;
// held characters are not cleared, as a frame only reads slots it wrote itself.
module motor_command_frame_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcfp_byte_if.sink  i_rx,
    mcfp_cmd_if.source o_cmd
);
    import mcfp_pkg::*;

    // Byte held in the input register, waiting for the core.
    logic              w_in_valid;
    logic [BYTE_W-1:0] w_in_byte;

    // Result slot is empty or drains this cycle.
    logic w_out_free;

    // Move the held byte through the core into the result slot.
    logic w_advance;

    // Decoded command from the core, valid only for a complete, clean frame.
    logic w_res_valid;
    t_cmd w_res;

    // Advance only when the result slot can take whatever the byte produces,
    // so a byte never leaves the input register without its result landing.
    assign w_advance = w_in_valid && w_out_free;

    // Input register: parts the byte source from the core so the next
    // request is taken while the current one is decoded.
    mcfp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_byte    (w_in_byte)
    );

    // Core: track the slot, hold body characters, check and decode at the terminator.
    mcfp_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_byte      (w_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Result register: hold a command until the sink takes it.
    mcfp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_free      (w_out_free),
        .o_cmd       (o_cmd)
    );
endmodule

/* hdl/mcfp_checker.sv */
// Port-level checks of the motor command frame parser, bound to its top level.
// Depends on mcfp_pkg and motor_command_frame_parser_defines.svh.
`include "motor_command_frame_parser_defines.svh"

module mcfp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_rx_valid,
    input logic                         i_rx_ready,
    input logic                         i_cmd_valid,
    input logic                         i_cmd_ready,
    input logic [mcfp_pkg::SPEED_W-1:0] i_speed_percent,
    input logic                         i_go_backward,
    input logic [mcfp_pkg::ANGLE_W-1:0] i_angle_value,
    input logic                         i_turn_left
);
    import mcfp_pkg::*;

    logic [SPEED_W+ANGLE_W+1:0] w_cmd_fields;
    logic                       w_cmd_in_range;
    logic                       w_cmd_stall;

    assign w_cmd_fields   = {i_speed_percent, i_go_backward, i_angle_value, i_turn_left};
    assign w_cmd_in_range = (i_speed_percent <= SPEED_MAX) && (i_angle_value <= ANGLE_MAX);
    assign w_cmd_stall    = i_cmd_valid && !i_cmd_ready;

    // A decoded command stays inside the frame's digit ranges.
    `MCFP_ASSERT_NOW(a_cmd_range, i_clk, i_rst_n, i_cmd_valid, w_cmd_in_range)

    // With no command pending the byte side must never stall.
    `MCFP_ASSERT_NOW(a_rx_ready_when_idle, i_clk, i_rst_n, !i_cmd_valid, i_rx_ready)

    // A stalled command holds its fields.
    `MCFP_ASSERT_NEXT(a_cmd_hold, i_clk, i_rst_n, w_cmd_stall, i_cmd_valid && $stable(w_cmd_fields))

    // Reset leaves no command pending.
    `MCFP_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !i_cmd_valid)

    // Ready is known whenever a byte is offered.
    `MCFP_ASSERT_NOW(a_rx_ready_known, i_clk, i_rst_n, i_rx_valid, !$isunknown(i_rx_ready))
endmodule

bind motor_command_frame_parser mcfp_checker u_mcfp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rx_valid      (i_rx.valid),
    .i_rx_ready      (i_rx.ready),
    .i_cmd_valid     (o_cmd.valid),
    .i_cmd_ready     (o_cmd.ready),
    .i_speed_percent (o_cmd.speed_percent),
    .i_go_backward   (o_cmd.go_backward),
    .i_angle_value   (o_cmd.angle_value),
    .i_turn_left     (o_cmd.turn_left)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the motor command frame parser: a directed table, then random frames.
// Depends on mcfp_pkg, the mcfp_byte_if / mcfp_cmd_if channels and motor_command_frame_parser.

module testbench;
    import mcfp_pkg::*;

    // Character slots of a frame body, in arrival order.
    localparam int unsigned SLOT_HUNDREDS    = 0;
    localparam int unsigned SLOT_TENS        = 1;
    localparam int unsigned SLOT_UNITS       = 2;
    localparam int unsigned SLOT_DIR         = 3;
    localparam int unsigned SLOT_ANGLE_TENS  = 4;
    localparam int unsigned SLOT_ANGLE_UNITS = 5;
    localparam int unsigned SLOT_SIDE        = 6;

    localparam int unsigned RANDOM_BYTES   = 1050;
    localparam int unsigned STALL_MAX      = 11;
    localparam int unsigned WATCHDOG_LIMIT = 500;
    localparam int unsigned DRAIN_CYCLES   = 8;

    typedef struct {
        logic [BYTE_W-1:0] rx_byte;
        bit                typed;   // the command below is the known answer of this row
        t_cmd              want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    mcfp_byte_if rx_if();
    mcfp_cmd_if  cmd_if();

    motor_command_frame_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_cmd   (cmd_if)
    );

    // Shadow of the parser state.
    logic [POS_W-1:0]  frame_slot;
    logic [BYTE_W-1:0] frame_chars [BODY_LEN];

    t_cmd        pending_cmds [$];
    t_stim_row   stim_rows [$];
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    int unsigned bytes_sent;
    int unsigned ready_hold;
    bit          idle_on;

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        cmd_if.ready   = 1'b0;
        frame_slot     = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        bytes_sent     = 0;
        ready_hold     = 0;
        idle_on        = 1'b1;
    end

    always #10 i_clk = ~i_clk;

    function automatic bit in_span(input logic [BYTE_W-1:0] c,
                                   input logic [BYTE_W-1:0] lo,
                                   input logic [BYTE_W-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    // Advance the shadow parser by one byte; return 1 when it completes a good frame.
    function automatic bit parse_rx_byte(input logic [BYTE_W-1:0] c, output t_cmd cmd);
        logic [POS_W-1:0]  slot;
        logic [BYTE_W-1:0] dir;
        logic [BYTE_W-1:0] side;
        bit                fields_ok;
        slot = frame_slot;
        cmd  = '0;
        dir  = frame_chars[SLOT_DIR];
        side = frame_chars[SLOT_SIDE];
        if (c == CH_TERM_UC || c == CH_TERM_LC) begin
            // Any terminator restarts framing; only one in the eighth slot can give a command.
            frame_slot = '0;
            if (slot != POS_LAST)
                return 1'b0;
            fields_ok = in_span(frame_chars[SLOT_HUNDREDS], CH_ZERO, CH_ONE)
                     && in_span(frame_chars[SLOT_TENS], CH_ZERO, CH_NINE)
                     && in_span(frame_chars[SLOT_UNITS], CH_ZERO, CH_NINE)
                     && (dir == CH_FWD_LC || dir == CH_FWD_UC
                         || dir == CH_BWD_LC || dir == CH_BWD_UC)
                     && in_span(frame_chars[SLOT_ANGLE_TENS], CH_ZERO, CH_FOUR)
                     && in_span(frame_chars[SLOT_ANGLE_UNITS], CH_ZERO, CH_NINE)
                     && (side == CH_LEFT_LC || side == CH_LEFT_UC
                         || side == CH_RGHT_LC || side == CH_RGHT_UC);
            if (!fields_ok)
                return 1'b0;
            cmd.speed_percent = SPEED_W'(100 * (frame_chars[SLOT_HUNDREDS] - CH_ZERO)
                                       + 10 * (frame_chars[SLOT_TENS] - CH_ZERO)
                                       + (frame_chars[SLOT_UNITS] - CH_ZERO));
            cmd.go_backward   = (dir == CH_BWD_LC || dir == CH_BWD_UC);
            cmd.angle_value   = ANGLE_W'(10 * (frame_chars[SLOT_ANGLE_TENS] - CH_ZERO)
                                       + (frame_chars[SLOT_ANGLE_UNITS] - CH_ZERO));
            cmd.turn_left     = (side == CH_LEFT_LC || side == CH_LEFT_UC);
            return 1'b1;
        end
        if (slot == POS_LAST) begin
            // Eighth byte is not a terminator: drop it together with the frame.
            frame_slot = '0;
            return 1'b0;
        end
        frame_chars[slot] = c;
        frame_slot        = slot + POS_W'(1);
        return 1'b0;
    endfunction

    // Push the characters of a text as table rows; the last one may carry a known command.
    task automatic add_text(input string text, input bit typed, input t_cmd want);
        t_stim_row row;
        for (int i = 0; i < text.len(); i++) begin
            row.rx_byte = text[i];
            row.typed   = typed && (i == text.len() - 1);
            row.want    = want;
            stim_rows.push_back(row);
        end
    endtask

    // Random character that passes the check of its slot.
    function automatic logic [BYTE_W-1:0] frame_char(input int unsigned slot);
        logic [1:0] pick;
        pick = 2'($urandom_range(0, 3));
        case (slot)
            SLOT_HUNDREDS:   return CH_ZERO + BYTE_W'($urandom_range(0, 1));
            SLOT_DIR: begin
                case (pick)
                    2'd0:    return CH_FWD_LC;
                    2'd1:    return CH_FWD_UC;
                    2'd2:    return CH_BWD_LC;
                    default: return CH_BWD_UC;
                endcase
            end
            SLOT_ANGLE_TENS: return CH_ZERO + BYTE_W'($urandom_range(0, 4));
            SLOT_SIDE: begin
                case (pick)
                    2'd0:    return CH_LEFT_LC;
                    2'd1:    return CH_LEFT_UC;
                    2'd2:    return CH_RGHT_LC;
                    default: return CH_RGHT_UC;
                endcase
            end
            default:         return CH_ZERO + BYTE_W'($urandom_range(0, 9));
        endcase
    endfunction

    // Byte likely to fail a check: anything, something near the digits, or a letter.
    function automatic logic [BYTE_W-1:0] corrupt_char();
        case ($urandom_range(0, 2))
            0:       return BYTE_W'($urandom_range(0, 255));
            1:       return BYTE_W'($urandom_range(8'h2E, 8'h3B));
            default: return BYTE_W'($urandom_range(8'h41, 8'h7A));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] any_term();
        return $urandom_range(0, 1) ? CH_TERM_UC : CH_TERM_LC;
    endfunction

    // Offer one byte, hold it until the request is taken, then predict its outcome.
    task automatic send_request(input logic [BYTE_W-1:0] b, input bit typed, input t_cmd want);
        t_cmd predicted;
        bit   produced;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, STALL_MAX)) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        produced = parse_rx_byte(b, predicted);
        if (typed)
            pending_cmds.push_back(want);
        else if (produced)
            pending_cmds.push_back(predicted);
        bytes_sent++;
    endtask

    // Drop valid and hold the sender until every outstanding command has come out.
    task automatic wait_for_drain();
        rx_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_cmds.size() != 0);
    endtask

    // Stimulus: reset, directed table, random frames, drain, verdict.
    initial begin
        logic [BYTE_W-1:0] frame_q [$];
        int unsigned       end_count;
        int unsigned       mid_count;
        int unsigned       kind;
        int unsigned       cut;
        bit                paused;
        paused = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Both extremes of every field, the early and the missing terminator,
        // and a bad sixth character in front of a proper terminator.
        add_text("199B49LE", 1'b1, t_cmd'({8'd199, 1'b1, 6'd49, 1'b1}));
        add_text("000f00re", 1'b1, t_cmd'({8'd0, 1'b0, 6'd0, 1'b0}));
        add_text("1E", 1'b0, '0);
        add_text("100F2:lE", 1'b0, '0);
        add_text("012b34Rx", 1'b0, '0);
        foreach (stim_rows[i])
            send_request(stim_rows[i].rx_byte, stim_rows[i].typed, stim_rows[i].want);
        wait_for_drain();

        end_count = bytes_sent + RANDOM_BYTES;
        mid_count = bytes_sent + RANDOM_BYTES / 2;
        while (bytes_sent < end_count) begin
            // Idle on both sides, except for one quiet stretch and the final part.
            idle_on = !((bytes_sent >= mid_count - 150 && bytes_sent < mid_count)
                        || bytes_sent >= end_count - 200);
            if (!paused && bytes_sent >= mid_count) begin
                paused = 1'b1;
                wait_for_drain();
            end

            frame_q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                for (int unsigned s = 0; s < BODY_LEN; s++)
                    frame_q.push_back(frame_char(s));
                frame_q.push_back(any_term());
            end
            if (kind >= 60 && kind < 85) begin
                // Break an otherwise good frame in one way.
                cut = $urandom_range(0, BODY_LEN - 1);
                case ($urandom_range(0, 2))
                    0: frame_q[cut] = corrupt_char();
                    1: frame_q[BODY_LEN] = corrupt_char();
                    default: begin
                        while (frame_q.size() > cut)
                            void'(frame_q.pop_back());
                        frame_q.push_back(any_term());
                    end
                endcase
            end else if (kind >= 85) begin
                // Line noise, half the time followed by a terminator to resync.
                repeat ($urandom_range(1, 10))
                    frame_q.push_back(BYTE_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 1))
                    frame_q.push_back(any_term());
            end
            foreach (frame_q[i])
                send_request(frame_q[i], 1'b0, '0);
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Command sink: drop ready in random stalls while idling is on.
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            cmd_if.ready <= 1'b0;
            ready_hold   <= $urandom_range(0, STALL_MAX - 1);
        end else begin
            cmd_if.ready <= 1'b1;
        end
    end

    // Compare each taken command with the oldest expected one.
    always @(posedge i_clk) begin
        t_cmd want;
        if (i_rst_n && cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) begin
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected command, expected none, actual %0d/%0d/%0d/%0d",
                         $time, cmd_if.speed_percent, cmd_if.go_backward,
                         cmd_if.angle_value, cmd_if.turn_left);
                mismatch_count++;
            end else begin
                want = pending_cmds.pop_front();
                if (cmd_if.speed_percent !== want.speed_percent) begin
                    $display("%0t: speed_percent expected %0d actual %0d",
                             $time, want.speed_percent, cmd_if.speed_percent);
                    mismatch_count++;
                end
                if (cmd_if.go_backward !== want.go_backward) begin
                    $display("%0t: go_backward expected %0d actual %0d",
                             $time, want.go_backward, cmd_if.go_backward);
                    mismatch_count++;
                end
                if (cmd_if.angle_value !== want.angle_value) begin
                    $display("%0t: angle_value expected %0d actual %0d",
                             $time, want.angle_value, cmd_if.angle_value);
                    mismatch_count++;
                end
                if (cmd_if.turn_left !== want.turn_left) begin
                    $display("%0t: turn_left expected %0d actual %0d",
                             $time, want.turn_left, cmd_if.turn_left);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no request moves on either side for too long.
    always @(posedge i_clk) begin
        if ((rx_if.valid === 1'b1 && rx_if.ready === 1'b1)
            || (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d commands outstanding",
                     $time, pending_cmds.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

/* motor_command_frame_parser.f */
+incdir+hdl
hdl/mcfp_pkg.sv
hdl/mcfp_if.sv
hdl/mcfp_in_stage.sv
hdl/mcfp_frame_core.sv
hdl/mcfp_out_stage.sv
hdl/motor_command_frame_parser.sv
hdl/mcfp_checker.sv
tb/sv/testbench.sv
